// ----- rtl/core/slcb_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the sequenced latest-command buffer.
// Depends on nothing; used by sequenced_latest_command_buffer_core under rtl/core.
package slcb_pkg;

    // Table geometry and stored field widths.
    localparam int NUM_IDS      = 64;
    localparam int SEQ_BITS     = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int IDX_W        = $clog2(NUM_IDS);
    localparam int CNT_W        = $clog2(NUM_IDS);
    localparam int ENTRY_W      = SEQ_BITS + PAYLOAD_BITS;

    // Fixed port field widths.
    localparam int FUNC_W  = 3;
    localparam int ID_W    = 6;
    localparam int IOSEQ_W = 32;
    localparam int IOPAY_W = 32;

    // Command codes.
    typedef enum logic [FUNC_W-1:0] {
        FN_ENQUEUE = 3'd0,
        FN_DRAIN   = 3'd1,
        FN_DISCARD = 3'd2,
        FN_REMOVE  = 3'd3,
        FN_CLEAR   = 3'd4
    } t_func;

endpackage

// ----- rtl/core/slcb_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with one write and one registered read port.
// Generic; depends on nothing.
module slcb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, old data on a same-address collision.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/sequenced_latest_command_buffer_core.sv -----
`timescale 1ns / 1ps
// Top level of the sequenced latest-command buffer: command FSM, valid flags,
// forwarding around the entry RAM. Depends on slcb_pkg and slcb_ram.
//
// Usage:
//   A command is transferred at a rising edge where start is high and busy
//   is low; i_func selects enqueue, drain, discard, remove or clear.
//   Each result is shown for exactly one cycle with o_valid high and is
//   taken at the edge that ends that cycle; the receiver cannot stall.
//   o_last marks the final result of a command.
//   Enqueue, discard, remove, clear and unknown codes: the entry RAM is read
//   on the transfer edge, the decision and write-back happen in the next
//   cycle, and the single result is registered at the end of it. busy is
//   high for one cycle, so a new command may be sent while the result is shown.
//   Drain: the walk reads one ID per cycle from the entry RAM and stops
//   after the last pending entry; results come out in ascending ID order,
//   possibly with idle gaps. An empty drain behaves like a single-result
//   command.
//   The sequence and payload of each ID share one RAM word; a write that
//   hits the address read on the same edge is forwarded.
//   Reset (synchronous, active low) clears all seen and pending flags and
//   the pending count at once; no clearing pass is needed.
module sequenced_latest_command_buffer_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [slcb_pkg::FUNC_W-1:0]  i_func,
    input  logic [slcb_pkg::ID_W-1:0]    i_entity_id,
    input  logic [slcb_pkg::IOSEQ_W-1:0] i_sequence_req,
    input  logic [slcb_pkg::IOPAY_W-1:0] i_payload,
    output logic                         o_valid,
    output logic                         o_ok,
    output logic                         o_item_valid,
    output logic [slcb_pkg::ID_W-1:0]    o_out_id,
    output logic [slcb_pkg::IOSEQ_W-1:0] o_out_sequence,
    output logic [slcb_pkg::IOPAY_W-1:0] o_out_payload,
    output logic                         o_last,
    output logic [slcb_pkg::ID_W-1:0]    o_pending_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DRAIN
    } t_state;

    // Control state.
    t_state                            r_state, n_state;
    logic [slcb_pkg::NUM_IDS-1:0]      r_seen, n_seen;
    logic [slcb_pkg::NUM_IDS-1:0]      r_pend, n_pend;
    logic [slcb_pkg::CNT_W-1:0]        r_total, n_total;
    logic [slcb_pkg::IDX_W-1:0]        r_idx, n_idx;
    logic [slcb_pkg::CNT_W-1:0]        r_remain, n_remain;
    logic                              r_rd_v, n_rd_v;
    logic [slcb_pkg::IDX_W-1:0]        r_rd_id, n_rd_id;
    logic                              r_fwd_hit, n_fwd_hit;
    logic [slcb_pkg::ENTRY_W-1:0]      r_fwd_data;

    // Captured command.
    slcb_pkg::t_func                   r_func;
    logic [slcb_pkg::IDX_W-1:0]        r_cidx;
    logic                              r_id_ok;
    logic [slcb_pkg::SEQ_BITS-1:0]     r_seq;
    logic [slcb_pkg::PAYLOAD_BITS-1:0] r_pay;

    // Registered result.
    logic                              r_o_valid, n_o_valid;
    logic                              r_o_ok, n_o_ok;
    logic                              r_o_iv, n_o_iv;
    logic [slcb_pkg::IDX_W-1:0]        r_o_id, n_o_id;
    logic [slcb_pkg::SEQ_BITS-1:0]     r_o_seq, n_o_seq;
    logic [slcb_pkg::PAYLOAD_BITS-1:0] r_o_pay, n_o_pay;
    logic                              r_o_last, n_o_last;
    logic [slcb_pkg::CNT_W-1:0]        r_o_cnt, n_o_cnt;

    // RAM access.
    logic                              ram_we;
    logic [slcb_pkg::IDX_W-1:0]        ram_waddr;
    logic [slcb_pkg::ENTRY_W-1:0]      ram_wdata;
    logic [slcb_pkg::IDX_W-1:0]        ram_raddr;
    logic [slcb_pkg::ENTRY_W-1:0]      ram_rdata;

    logic                              accept;
    logic                              in_id_ok;
    logic [slcb_pkg::IDX_W-1:0]        in_idx;
    logic [slcb_pkg::ENTRY_W-1:0]      rd_data;
    logic [slcb_pkg::SEQ_BITS-1:0]     rd_seq;
    logic [slcb_pkg::PAYLOAD_BITS-1:0] rd_pay;
    logic                              enq_ok;

    slcb_ram #(
        .DEPTH (slcb_pkg::NUM_IDS),
        .WIDTH (slcb_pkg::ENTRY_W)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Input decode.
    assign accept   = start && (r_state == ST_IDLE);
    assign in_id_ok = (i_entity_id != '0)
        && ({1'b0, i_entity_id} < (slcb_pkg::ID_W + 1)'(slcb_pkg::NUM_IDS));
    assign in_idx   = slcb_pkg::IDX_W'(i_entity_id);

    // Read address: the command's ID when idle, the walk pointer in a drain.
    assign ram_raddr = (r_state == ST_DRAIN) ? r_idx : in_idx;

    // Read data with forwarding of a write that landed on the same edge.
    assign rd_data = r_fwd_hit ? r_fwd_data : ram_rdata;
    assign rd_seq  = rd_data[slcb_pkg::ENTRY_W-1:slcb_pkg::PAYLOAD_BITS];
    assign rd_pay  = rd_data[slcb_pkg::PAYLOAD_BITS-1:0];

    // Enqueue is taken when the ID and sequence are valid and the sequence is new.
    assign enq_ok = r_id_ok && (r_seq != '0)
        && !(r_seen[r_cidx] && (r_seq <= rd_seq));

    assign ram_waddr = r_cidx;
    assign ram_wdata = {r_seq, r_pay};
    assign n_fwd_hit = ram_we && (ram_waddr == ram_raddr);

    // Next-state and result logic.
    always_comb begin
        n_state   = r_state;
        n_seen    = r_seen;
        n_pend    = r_pend;
        n_total   = r_total;
        n_idx     = r_idx;
        n_remain  = r_remain;
        n_rd_v    = 1'b0;
        n_rd_id   = r_idx;
        n_o_valid = 1'b0;
        n_o_ok    = 1'b0;
        n_o_iv    = 1'b0;
        n_o_id    = '0;
        n_o_seq   = '0;
        n_o_pay   = '0;
        n_o_last  = 1'b0;
        n_o_cnt   = r_o_cnt;
        ram_we    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (slcb_pkg::t_func'(i_func) == slcb_pkg::FN_DRAIN) begin
                        n_total = '0;
                        if (r_total == '0) begin
                            n_state = ST_EXEC;
                        end else begin
                            n_state  = ST_DRAIN;
                            n_idx    = '0;
                            n_remain = r_total;
                        end
                    end else begin
                        n_state = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                n_state   = ST_IDLE;
                n_o_valid = 1'b1;
                n_o_last  = 1'b1;
                unique case (r_func)
                    slcb_pkg::FN_ENQUEUE: begin
                        if (enq_ok) begin
                            n_o_ok         = 1'b1;
                            ram_we         = 1'b1;
                            n_seen[r_cidx] = 1'b1;
                            if (!r_pend[r_cidx]) begin
                                n_pend[r_cidx] = 1'b1;
                                n_total        = r_total + 1'b1;
                            end
                        end
                    end
                    slcb_pkg::FN_DISCARD: begin
                        if (r_id_ok && r_pend[r_cidx]) begin
                            n_pend[r_cidx] = 1'b0;
                            n_total        = r_total - 1'b1;
                            n_o_ok         = 1'b1;
                            n_o_iv         = 1'b1;
                            n_o_id         = r_cidx;
                            n_o_seq        = rd_seq;
                        end
                    end
                    slcb_pkg::FN_REMOVE: begin
                        if (r_id_ok) begin
                            if (r_pend[r_cidx]) begin
                                n_pend[r_cidx] = 1'b0;
                                n_total        = r_total - 1'b1;
                            end
                            n_seen[r_cidx] = 1'b0;
                        end
                    end
                    slcb_pkg::FN_CLEAR: begin
                        n_seen  = '0;
                        n_pend  = '0;
                        n_total = '0;
                    end
                    default: begin
                        // Empty drain and unknown codes leave the state alone.
                    end
                endcase
                n_o_cnt = n_total;
            end
            ST_DRAIN: begin
                // Issue the read for the next ID and take its pending flag.
                n_rd_v        = r_pend[r_idx];
                n_rd_id       = r_idx;
                n_pend[r_idx] = 1'b0;
                n_idx         = r_idx + 1'b1;
                // Report the ID read in the previous cycle if it was pending.
                if (r_rd_v) begin
                    n_o_valid = 1'b1;
                    n_o_iv    = 1'b1;
                    n_o_id    = r_rd_id;
                    n_o_seq   = rd_seq;
                    n_o_pay   = rd_pay;
                    n_o_last  = (r_remain == slcb_pkg::CNT_W'(1));
                    n_o_cnt   = '0;
                    n_remain  = r_remain - 1'b1;
                    if (r_remain == slcb_pkg::CNT_W'(1)) begin
                        n_state = ST_IDLE;
                        n_rd_v  = 1'b0;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State, flags and registered outputs.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_remain   <= n_remain;
        r_rd_id    <= n_rd_id;
        r_fwd_data <= ram_wdata;
        r_o_ok     <= n_o_ok;
        r_o_iv     <= n_o_iv;
        r_o_id     <= n_o_id;
        r_o_seq    <= n_o_seq;
        r_o_pay    <= n_o_pay;
        r_o_last   <= n_o_last;
        r_o_cnt    <= n_o_cnt;
        if (accept) begin
            r_func  <= slcb_pkg::t_func'(i_func);
            r_cidx  <= in_idx;
            r_id_ok <= in_id_ok;
            r_seq   <= slcb_pkg::SEQ_BITS'(i_sequence_req);
            r_pay   <= slcb_pkg::PAYLOAD_BITS'(i_payload);
        end
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_seen    <= '0;
            r_pend    <= '0;
            r_total   <= '0;
            r_rd_v    <= 1'b0;
            r_fwd_hit <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_seen    <= n_seen;
            r_pend    <= n_pend;
            r_total   <= n_total;
            r_rd_v    <= n_rd_v;
            r_fwd_hit <= n_fwd_hit;
            r_o_valid <= n_o_valid;
        end
    end

    // Output ports.
    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_o_valid;
    assign o_ok            = r_o_ok;
    assign o_item_valid    = r_o_iv;
    assign o_out_id        = slcb_pkg::ID_W'(r_o_id);
    assign o_out_sequence  = slcb_pkg::IOSEQ_W'(r_o_seq);
    assign o_out_payload   = slcb_pkg::IOPAY_W'(r_o_pay);
    assign o_last          = r_o_last;
    assign o_pending_count = slcb_pkg::ID_W'(r_o_cnt);

    // The pending count tracks the pending flags outside a drain walk.
    a_total_matches_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_DRAIN) |-> ($countones(r_pend) == int'(r_total)))
        else $error("pending count differs from pending flags");

    // ID zero can never hold a pending entry.
    a_id_zero_never_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pend[0])
        else $error("ID zero marked pending");

    // A drained entry is reported with an empty table count.
    a_drain_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item_valid && !o_ok) |-> (o_pending_count == '0))
        else $error("drain result with nonzero pending count");

    // Results without the last mark only come out of a drain walk.
    a_multi_only_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_state == ST_DRAIN))
        else $error("non-final result outside a drain");

endmodule
